### hdl/rgr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgr_pkg
// shared types, constants and the microcode table of the glyph rasterizer
// ---------------------------------------------------------------------------
package rgr_pkg;

	localparam int unsigned SCREEN_WIDTH  = 320;
	localparam int unsigned SCREEN_HEIGHT = 240;

	localparam logic [8:0] SCREEN_W  = 9'(SCREEN_WIDTH);
	localparam logic [8:0] SCREEN_H  = 9'(SCREEN_HEIGHT);
	localparam logic [8:0] SCREEN_W1 = 9'(SCREEN_WIDTH - 1);
	localparam logic [8:0] SCREEN_H1 = 9'(SCREEN_HEIGHT - 1);

	localparam logic [15:0] COLOR_FG = 16'hffff;
	localparam logic [15:0] COLOR_BG = 16'h0000;

	// configuration register indexes
	localparam logic [1:0] REG_GLYPH_SIZE   = 2'd0;
	localparam logic [1:0] REG_OVERLAY_MODE = 2'd1;
	localparam logic [1:0] REG_ROTATION     = 2'd2;

	// rotations
	localparam logic [1:0] ROT_UP    = 2'd0;
	localparam logic [1:0] ROT_LEFT  = 2'd1;
	localparam logic [1:0] ROT_RIGHT = 2'd2;
	localparam logic [1:0] ROT_DOWN  = 2'd3;

	// microcode steps
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_PIXEL = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	// jump conditions
	localparam logic [1:0] C_ALWAYS  = 2'd0;
	localparam logic [1:0] C_NO_ITEM = 2'd1;
	localparam logic [1:0] C_SKIP    = 2'd2;
	localparam logic [1:0] C_NO_BRK  = 2'd3;

	typedef struct packed {
		logic [5:0] glyph_size;
		logic       overlay_mode;
		logic [1:0] rotation;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic start;
		logic pixel;
		logic flush;
	} ctrl_t;

	typedef struct packed {
		logic skip;
		logic brk;
		logic stall;
		logic pend_v;
	} flags_t;

	typedef struct packed {
		logic [1:0] cond;
		logic [1:0] target;
		ctrl_t      act;
	} uword_t;

	function automatic uword_t ucode_rom(input logic [1:0] step);
		uword_t w;
		w = '0;
		case (step)
			ST_IDLE: begin
				w.cond     = C_NO_ITEM;
				w.target   = ST_IDLE;
				w.act.take = 1'b1;
			end
			ST_CHECK: begin
				w.cond      = C_SKIP;
				w.target    = ST_IDLE;
				w.act.start = 1'b1;
			end
			ST_PIXEL: begin
				w.cond      = C_NO_BRK;
				w.target    = ST_PIXEL;
				w.act.pixel = 1'b1;
			end
			ST_FLUSH: begin
				w.cond      = C_ALWAYS;
				w.target    = ST_IDLE;
				w.act.flush = 1'b1;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// bytes per character, zero for an unsupported size
	function automatic logic [6:0] bytes_per_char(input logic [5:0] size);
		logic [6:0] n;
		case (size)
			6'd12:   n = 7'd12;
			6'd16:   n = 7'd16;
			6'd24:   n = 7'd36;
			6'd32:   n = 7'd64;
			default: n = 7'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

### hdl/rgr_sequencer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgr_sequencer
// step counter over the microcode table with conditional jumps
// ---------------------------------------------------------------------------
module rgr_sequencer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire rgr_pkg::flags_t flags,
	output rgr_pkg::ctrl_t      ctrl
);
	import rgr_pkg::*;

	logic [1:0] upc_q;
	uword_t     uw;
	logic       jump;

	always_comb begin
		uw   = ucode_rom(upc_q);
		ctrl = uw.act;
		case (uw.cond)
			C_ALWAYS:  jump = 1'b1;
			C_NO_ITEM: jump = !item_valid;
			C_SKIP:    jump = flags.skip;
			C_NO_BRK:  jump = !flags.brk;
			default:   jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else if (!flags.stall) begin
			upc_q <= jump ? uw.target : upc_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

### hdl/rgr_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgr_datapath
// cursor state, pixel mapping, hold stage and result register
// ---------------------------------------------------------------------------
module rgr_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rgr_pkg::cfg_t   cfg,
	input  wire rgr_pkg::ctrl_t  ctrl,
	input  wire logic            item_valid,
	input  wire logic            first_byte,
	input  wire logic [8:0]      origin_x,
	input  wire logic [8:0]      origin_y,
	input  wire logic [7:0]      glyph_byte,
	output rgr_pkg::flags_t      flags,
	output logic                 pix_valid,
	input  wire logic            pix_ready,
	output logic [16:0]          pixel_address,
	output logic [15:0]          pixel_color,
	output logic                 last
);
	import rgr_pkg::*;

	logic [8:0]  cursor_x_q, cursor_y_q, column_top_q;
	logic [6:0]  bytes_taken_q;
	logic        char_ended_q;
	logic [7:0]  bits_q;
	logic [2:0]  step_q;
	logic        pend_v_q, pend_set_q;
	logic [16:0] pend_addr_q;
	logic        out_v_q, out_set_q, out_last_q;
	logic [16:0] out_addr_q;

	logic [6:0]  total, bytes_nx;
	logic        skip, swap, in_bounds, emit, take, stall, out_load;
	logic [8:0]  row_lim, col_lim, mul_op, add_op;
	logic [18:0] addr_full;
	logic [9:0]  y_nx, x_nx, y_span;
	logic        edge_hit, col_hit, brk, ended;

	always_comb begin
		total    = bytes_per_char(cfg.glyph_size);
		bytes_nx = bytes_taken_q + 7'd1;
		skip     = char_ended_q || total == 7'd0 || bytes_taken_q >= total;
		swap     = cfg.rotation == ROT_LEFT || cfg.rotation == ROT_RIGHT;
		row_lim  = swap ? SCREEN_W : SCREEN_H;
		col_lim  = swap ? SCREEN_H : SCREEN_W;
		in_bounds = cursor_x_q < col_lim && cursor_y_q < row_lim;

		case (cfg.rotation)
			ROT_UP: begin
				mul_op = cursor_y_q;
				add_op = cursor_x_q;
			end
			ROT_LEFT: begin
				mul_op = cursor_x_q;
				add_op = SCREEN_W1 - cursor_y_q;
			end
			ROT_RIGHT: begin
				mul_op = SCREEN_H1 - cursor_x_q;
				add_op = cursor_y_q;
			end
			default: begin
				mul_op = SCREEN_H1 - cursor_y_q;
				add_op = SCREEN_W1 - cursor_x_q;
			end
		endcase
		addr_full = 19'(SCREEN_W) * 19'(mul_op) + 19'(add_op);

		emit     = (bits_q[7] || !cfg.overlay_mode) && in_bounds;
		y_nx     = {1'b0, cursor_y_q} + 10'd1;
		x_nx     = {1'b0, cursor_x_q} + 10'd1;
		y_span   = y_nx - {1'b0, column_top_q};
		edge_hit = y_nx >= {1'b0, row_lim};
		col_hit  = y_span == {4'b0, cfg.glyph_size};
		brk      = edge_hit || col_hit || step_q == 3'd7;
		ended    = edge_hit || (col_hit && x_nx >= {1'b0, col_lim});

		take     = ctrl.take && item_valid;
		stall    = ((ctrl.pixel && emit) || ctrl.flush) && pend_v_q && out_v_q && !pix_ready;
		out_load = !stall && pend_v_q && ((ctrl.pixel && emit) || ctrl.flush);

		flags.skip   = skip;
		flags.brk    = brk;
		flags.stall  = stall;
		flags.pend_v = pend_v_q;
	end

	// character state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			column_top_q  <= '0;
			bytes_taken_q <= '0;
			char_ended_q  <= 1'b1;
			step_q        <= '0;
		end else begin
			if (take && first_byte) begin
				cursor_x_q    <= origin_x;
				cursor_y_q    <= origin_y;
				column_top_q  <= origin_y;
				bytes_taken_q <= '0;
				char_ended_q  <= 1'b0;
			end
			if (ctrl.start) begin
				step_q <= '0;
				if (skip) begin
					char_ended_q <= 1'b1;
				end
			end
			if (ctrl.pixel && !stall) begin
				step_q <= step_q + 3'd1;
				if (edge_hit) begin
					cursor_y_q <= y_nx[8:0];
				end else if (col_hit) begin
					cursor_y_q <= column_top_q;
					cursor_x_q <= x_nx[8:0];
				end else begin
					cursor_y_q <= y_nx[8:0];
				end
				if (brk) begin
					bytes_taken_q <= bytes_nx;
					char_ended_q  <= ended || bytes_nx >= total;
				end
			end
		end
	end

	// hold stage and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctrl.pixel && emit && !stall) begin
				pend_v_q <= 1'b1;
			end else if (ctrl.flush && !stall) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (pix_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			bits_q <= glyph_byte;
		end else if (ctrl.pixel && !stall) begin
			bits_q <= {bits_q[6:0], 1'b0};
		end
		if (ctrl.pixel && emit && !stall) begin
			pend_addr_q <= addr_full[16:0];
			pend_set_q  <= bits_q[7];
		end
		if (out_load) begin
			out_addr_q <= pend_addr_q;
			out_set_q  <= pend_set_q;
			out_last_q <= ctrl.flush;
		end
	end

	assign pix_valid     = out_v_q;
	assign pixel_address = out_addr_q;
	assign pixel_color   = out_set_q ? COLOR_FG : COLOR_BG;
	assign last          = out_last_q;

endmodule
`default_nettype wire

### hdl/rotated_glyph_rasterizer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rotated_glyph_rasterizer_unit
// turns glyph column bytes into rotated framebuffer pixel writes
// ---------------------------------------------------------------------------
// a byte walks n = 1..8 pixels, one per cycle in the pixel step unless a blocked result stalls it
// a byte that is skipped (no character, bad size, count reached) goes from the check step back to idle
// pixel writes pass the hold stage, then the result register; a byte's last one moves on at the flush step
// the result register lets the next byte in while a pixel still waits
// reset: size 16, opaque, rotation up, no character active
// ---------------------------------------------------------------------------
module rotated_glyph_rasterizer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        first_byte,
	input  wire logic [8:0]  origin_x,
	input  wire logic [8:0]  origin_y,
	input  wire logic [7:0]  glyph_byte,
	output logic             pix_valid,
	input  wire logic        pix_ready,
	output logic [16:0]      pixel_address,
	output logic [15:0]      pixel_color,
	output logic             last
);
	import rgr_pkg::*;

	cfg_t   cfg_q;
	ctrl_t  ctrl;
	flags_t flags;

	assign cfg_ready  = 1'b1;
	assign item_ready = ctrl.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_size   <= 6'd16;
			cfg_q.overlay_mode <= 1'b0;
			cfg_q.rotation     <= ROT_UP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GLYPH_SIZE:   cfg_q.glyph_size   <= cfg_data;
				REG_OVERLAY_MODE: cfg_q.overlay_mode <= cfg_data[0];
				REG_ROTATION:     cfg_q.rotation     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	rgr_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.flags      (flags),
		.ctrl       (ctrl)
	);

	rgr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.ctrl          (ctrl),
		.item_valid    (item_valid),
		.first_byte    (first_byte),
		.origin_x      (origin_x),
		.origin_y      (origin_y),
		.glyph_byte    (glyph_byte),
		.flags         (flags),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last          (last)
	);

	// a stall only comes from a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		flags.stall |-> pix_valid && !pix_ready)
		else $error("stall without a blocked result");

	// the hold stage is drained before a new byte is taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !flags.pend_v)
		else $error("pending pixel left behind at idle");

	// the end of a pixel walk is followed by the flush step
	a_brk_flush: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pixel && flags.brk && !flags.stall |=> ctrl.flush)
		else $error("pixel walk did not end in flush");

	// a new request is never taken in the cycle after a flush that is stalled
	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.flush && flags.stall |=> ctrl.flush && !item_ready)
		else $error("stalled flush left its step");

endmodule
`default_nettype wire
